@@ sv/mmrm_pkg.sv @@
// ----------------------------------------------------------------------------
// Memory map region merger package
// Shared transaction types, memory type codes and sizing constants.
// ----------------------------------------------------------------------------
package mmrm_pkg;

	// Default entry cap and page size, handed to the top level parameters.
	localparam int MAX_REGIONS_DEFAULT = 128;
	localparam int PAGE_BITS_DEFAULT   = 12;

	// Depth of the queue between the classifier and the merge engine.
	localparam int QUEUE_DEPTH = 4;

	// Firmware memory type codes that are kept.
	localparam logic [7:0] MT_LOADER_CODE    = 8'd1;
	localparam logic [7:0] MT_LOADER_DATA    = 8'd2;
	localparam logic [7:0] MT_BOOT_SVC_CODE  = 8'd3;
	localparam logic [7:0] MT_BOOT_SVC_DATA  = 8'd4;
	localparam logic [7:0] MT_CONVENTIONAL   = 8'd7;
	localparam logic [7:0] MT_ACPI_RECLAIM   = 8'd9;

	// Region classes.
	localparam logic CLASS_RAM  = 1'b0;
	localparam logic CLASS_ACPI = 1'b1;

	// One firmware descriptor as it arrives.
	typedef struct packed {
		logic [7:0]  mem_type;
		logic [63:0] base_address;
		logic [51:0] page_count;
		logic        final_descriptor;
	} in_item_t;

	// One emitted region or the empty-map report.
	typedef struct packed {
		logic        is_entry;
		logic [63:0] region_address;
		logic [63:0] region_size;
		logic        region_class;
		logic        map_done;
		logic [7:0]  entries_total;
	} out_item_t;

	// A classified descriptor waiting in the queue.
	typedef struct packed {
		logic        usable;
		logic        cls;
		logic [63:0] base;
		logic [63:0] bytes;
		logic        last;
	} desc_t;

	// Handshake status of the queue.
	typedef struct packed {
		logic push_ready;
		logic pop_valid;
	} queue_status_t;

endpackage

@@ sv/memory_map_region_merger_top.sv @@
// ----------------------------------------------------------------------------
// Memory map region merger
// Turns a firmware memory map into a list of merged RAM and ACPI regions.
// ----------------------------------------------------------------------------
// Usage:
//   The input channel takes one firmware descriptor per transaction. Loader,
//   boot-service and conventional types become RAM regions, ACPI reclaim
//   becomes an ACPI region, and all other types are dropped. Adjacent
//   descriptors of the same class are merged into one pending region.
//   The output channel carries one transaction per emitted region; the
//   final descriptor flushes the pending region with map_done set, or gives
//   a single report with is_entry clear when the map held no region.
//   Once the entry cap is reached, further descriptors of the map are ignored.
//   An accepted descriptor is written into the queue, and its result is
//   loaded into the output register when the merge engine pops it. One
//   descriptor is taken every cycle while the queue has room; one that
//   gives two results holds its second until the single output register frees.
//   A four-entry queue separates classification from merging, so input
//   keeps flowing while the receiver stalls until that queue is full.
//   Reset clears the pending region, the count, the queue and the output.
// ----------------------------------------------------------------------------
module memory_map_region_merger_top import mmrm_pkg::*; #(
	parameter int MAX_REGIONS = MAX_REGIONS_DEFAULT,
	parameter int PAGE_BITS   = PAGE_BITS_DEFAULT
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	input  in_item_t  in_data,
	output logic      out_valid,
	input  logic      out_ready,
	output out_item_t out_data
);

	logic          push_valid;
	desc_t         push_data;
	logic          pop;
	desc_t         pop_data;
	queue_status_t q_status;

	// Classification of incoming descriptors.
	mmrm_front #(
		.PAGE_BITS (PAGE_BITS)
	) u_front (
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.in_data    (in_data),
		.push_ready (q_status.push_ready),
		.push_valid (push_valid),
		.push_data  (push_data)
	);

	// Decoupling queue.
	mmrm_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_data  (push_data),
		.pop        (pop),
		.pop_data   (pop_data),
		.status     (q_status)
	);

	// Region merging and result output.
	mmrm_back #(
		.MAX_REGIONS (MAX_REGIONS)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.desc_valid (q_status.pop_valid),
		.desc       (pop_data),
		.pop        (pop),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.out_data   (out_data)
	);

endmodule

@@ sv/mmrm_front.sv @@
// ----------------------------------------------------------------------------
// Memory map region merger front end
// Accepts descriptors, classifies the memory type and sizes the region.
// ----------------------------------------------------------------------------
module mmrm_front import mmrm_pkg::*; #(
	parameter int PAGE_BITS = PAGE_BITS_DEFAULT
) (
	input  logic     in_valid,
	output logic     in_ready,
	input  in_item_t in_data,
	input  logic     push_ready,
	output logic     push_valid,
	output desc_t    push_data
);

	logic usable;
	logic cls;

	// Map the firmware type code to a region class.
	always_comb begin
		usable = 1'b1;
		cls    = CLASS_RAM;
		case (in_data.mem_type) inside
			MT_LOADER_CODE, MT_LOADER_DATA, MT_BOOT_SVC_CODE,
			MT_BOOT_SVC_DATA, MT_CONVENTIONAL: begin
				cls = CLASS_RAM;
			end
			MT_ACPI_RECLAIM: begin
				cls = CLASS_ACPI;
			end
			default: begin
				usable = 1'b0;
			end
		endcase
	end

	// A transaction passes straight into the queue when it has room.
	assign in_ready   = push_ready;
	assign push_valid = in_valid;

	always_comb begin
		push_data.usable = usable;
		push_data.cls    = cls;
		push_data.base   = in_data.base_address;
		push_data.bytes  = 64'(in_data.page_count) << PAGE_BITS;
		push_data.last   = in_data.final_descriptor;
	end

endmodule

@@ sv/mmrm_queue.sv @@
// ----------------------------------------------------------------------------
// Memory map region merger queue
// Short first-in first-out buffer between the front end and the merge engine.
// ----------------------------------------------------------------------------
module mmrm_queue import mmrm_pkg::*; (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push_valid,
	input  desc_t         push_data,
	input  logic          pop,
	output desc_t         pop_data,
	output queue_status_t status
);

	localparam int PtrW = $clog2(QUEUE_DEPTH);
	localparam logic [PtrW:0] FullCount = (PtrW + 1)'(QUEUE_DEPTH);

	desc_t           mem_q [QUEUE_DEPTH];
	logic [PtrW-1:0] wr_ptr_q;
	logic [PtrW-1:0] rd_ptr_q;
	logic [PtrW:0]   count_q;
	logic            push;
	logic            do_pop;

	assign status.push_ready = (count_q != FullCount);
	assign status.pop_valid  = (count_q != '0);
	assign push              = push_valid && status.push_ready;
	assign do_pop            = pop && status.pop_valid;
	assign pop_data          = mem_q[rd_ptr_q];

	// Storage for queued transactions.
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

@@ sv/mmrm_back.sv @@
// ----------------------------------------------------------------------------
// Memory map region merger back end
// Merges classified descriptors into the pending region and emits results.
// ----------------------------------------------------------------------------
module mmrm_back import mmrm_pkg::*; #(
	parameter int MAX_REGIONS = MAX_REGIONS_DEFAULT
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      desc_valid,
	input  desc_t     desc,
	output logic      pop,
	output logic      out_valid,
	input  logic      out_ready,
	output out_item_t out_data
);

	localparam logic [7:0] CapCount = 8'(MAX_REGIONS);

	// Pending region.
	logic [63:0] open_addr_q;
	logic [63:0] open_size_q;
	logic        open_class_q;
	logic        open_valid_q;
	logic [7:0]  count_q;

	// Output register and the second result of a two-result transaction.
	logic        out_valid_q;
	out_item_t   out_data_q;
	logic        pend_valid_q;
	out_item_t   pend_data_q;

	logic        out_free;
	logic        take;
	logic        merge;
	logic        start;
	logic        emit_old;
	logic [63:0] n_addr;
	logic [63:0] n_size;
	logic        n_class;
	logic        n_valid;
	logic [7:0]  n_count;
	out_item_t   res_old;
	out_item_t   res_flush;

	assign out_free = !out_valid_q || out_ready;
	assign pop      = desc_valid && !pend_valid_q && out_free;

	// Decide whether the descriptor extends the pending region or opens one.
	always_comb begin
		take     = desc.usable && (count_q < CapCount);
		merge    = take && open_valid_q && (open_class_q == desc.cls) &&
			((open_addr_q + open_size_q) == desc.base);
		start    = take && !merge;
		emit_old = start && open_valid_q;

		n_addr  = open_addr_q;
		n_size  = open_size_q;
		n_class = open_class_q;
		n_valid = open_valid_q;
		n_count = count_q;
		if (merge) begin
			n_size = open_size_q + desc.bytes;
		end else if (start) begin
			n_addr  = desc.base;
			n_size  = desc.bytes;
			n_class = desc.cls;
			n_valid = 1'b1;
			n_count = count_q + 8'd1;
		end
	end

	// Region closed by a new start, and the flush result of the final descriptor.
	always_comb begin
		res_old.is_entry       = 1'b1;
		res_old.region_address = open_addr_q;
		res_old.region_size    = open_size_q;
		res_old.region_class   = open_class_q;
		res_old.map_done       = 1'b0;
		res_old.entries_total  = count_q;

		res_flush.is_entry       = n_valid;
		res_flush.region_address = n_valid ? n_addr : '0;
		res_flush.region_size    = n_valid ? n_size : '0;
		res_flush.region_class   = n_valid ? n_class : CLASS_RAM;
		res_flush.map_done       = 1'b1;
		res_flush.entries_total  = n_valid ? n_count : '0;
	end

	// Merge state update; the final descriptor returns it to the reset values.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			open_addr_q  <= '0;
			open_size_q  <= '0;
			open_class_q <= CLASS_RAM;
			open_valid_q <= 1'b0;
			count_q      <= '0;
		end else if (pop) begin
			if (desc.last) begin
				open_addr_q  <= '0;
				open_size_q  <= '0;
				open_class_q <= CLASS_RAM;
				open_valid_q <= 1'b0;
				count_q      <= '0;
			end else begin
				open_addr_q  <= n_addr;
				open_size_q  <= n_size;
				open_class_q <= n_class;
				open_valid_q <= n_valid;
				count_q      <= n_count;
			end
		end
	end

	// Output control: the held second result goes out before the next pop.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			pend_valid_q <= 1'b0;
		end else if (out_free) begin
			if (pend_valid_q) begin
				out_valid_q  <= 1'b1;
				pend_valid_q <= 1'b0;
			end else begin
				out_valid_q  <= pop && (emit_old || desc.last);
				pend_valid_q <= pop && emit_old && desc.last;
			end
		end
	end

	// Output payload.
	always_ff @(posedge clk) begin
		if (out_free) begin
			if (pend_valid_q) begin
				out_data_q <= pend_data_q;
			end else if (emit_old) begin
				out_data_q  <= res_old;
				pend_data_q <= res_flush;
			end else begin
				out_data_q <= res_flush;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

endmodule
